@@ rtl/core/assert_macros.svh @@
// Assertion shorthands used by the checker file kld_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KLD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kld assertion failed: %m");

// Next-cycle implication, disabled while reset is asserted.
`define KLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kld assertion failed: %m");

`endif

@@ rtl/core/kld_pkg.sv @@
package kld_pkg;

    localparam int MSB_W      = 5;
    localparam int LOG_FRAC   = 30;
    localparam int SUM_W      = 48;
    localparam int MAG_W      = 40;

    localparam logic signed [SUM_W+1:0] SUM_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W+1:0] SUM_MIN = -50'sh0_8000_0000_0000;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LZ,
        OP_NORM,
        OP_TAB,
        OP_IMUL,
        OP_NL,
        OP_DIFF,
        OP_PMUL,
        OP_ACC,
        OP_EMIT
    } kld_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LZ,
        ST_NORM,
        ST_TAB,
        ST_IMUL,
        ST_NL,
        ST_DIFF,
        ST_PMUL,
        ST_ACC,
        ST_EMIT
    } kld_state_t;

    typedef struct packed {
        kld_op_t op;
        logic    sel_q;
    } kld_cmd_t;

    typedef struct packed {
        logic has_zero;
        logic last;
    } kld_status_t;

    // log2(1 + i/2^ltb) in unsigned Q.30 by repeated squaring; only used to
    // build the constant table at elaboration.
    function automatic logic [30:0] kld_log_entry(input int unsigned i, input int unsigned ltb);
        longint unsigned y;
        longint unsigned res;
        int k;
        res = 64'd0;
        if (i >= (32'd1 << ltb))
        begin
            return 31'h4000_0000;
        end
        y = (64'd1 << LOG_FRAC) + (longint'(i) << (LOG_FRAC - ltb));
        for (k = 29; k >= 0; k--)
        begin
            y = (y * y) >> LOG_FRAC;
            if (y >= (64'd2 << LOG_FRAC))
            begin
                y = y >> 1;
                res = res | (64'd1 << k);
            end
        end
        return res[30:0];
    endfunction

endpackage

@@ rtl/core/kld_pair_if.sv @@
interface kld_pair_if;
    logic        valid;
    logic        ready;
    logic [31:0] p_value;
    logic [31:0] q_value;
    logic        last_pair;

    modport source (output valid, output p_value, output q_value, output last_pair,
                    input ready);
    modport sink (input valid, input p_value, input q_value, input last_pair,
                  output ready);
endinterface

@@ rtl/core/kld_result_if.sv @@
interface kld_result_if;
    logic        valid;
    logic        ready;
    logic [47:0] divergence;
    logic        invalid_run;
    logic        saturated;

    modport source (output valid, output divergence, output invalid_run, output saturated,
                    input ready);
    modport sink (input valid, input divergence, input invalid_run, input saturated,
                  output ready);
endinterface

@@ rtl/core/kld_ctrl.sv @@
module kld_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pair_valid,
    output logic                pair_ready,
    output logic                result_valid,
    input  logic                result_ready,
    input  kld_pkg::kld_status_t status,
    output kld_pkg::kld_cmd_t   cmd
);

    kld_pkg::kld_state_t state_reg;
    kld_pkg::kld_state_t state_next;
    logic                sel_q_reg;
    logic                sel_q_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kld_pkg::ST_IDLE;
            sel_q_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_q_reg     <= sel_q_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_q_next     = sel_q_reg;
        out_valid_next = out_valid_reg && !result_ready;
        pair_ready     = 1'b0;
        cmd.op         = kld_pkg::OP_NONE;
        cmd.sel_q      = sel_q_reg;
        case (state_reg)
            kld_pkg::ST_IDLE:
            begin
                pair_ready = 1'b1;
                if (pair_valid)
                begin
                    cmd.op     = kld_pkg::OP_LOAD;
                    sel_q_next = 1'b0;
                    state_next = kld_pkg::ST_LZ;
                end
            end
            kld_pkg::ST_LZ:
            begin
                // A zero probability skips the whole term.
                if (status.has_zero)
                begin
                    state_next = status.last ? kld_pkg::ST_EMIT : kld_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.op     = kld_pkg::OP_LZ;
                    state_next = kld_pkg::ST_NORM;
                end
            end
            kld_pkg::ST_NORM:
            begin
                cmd.op     = kld_pkg::OP_NORM;
                state_next = kld_pkg::ST_TAB;
            end
            kld_pkg::ST_TAB:
            begin
                cmd.op     = kld_pkg::OP_TAB;
                state_next = kld_pkg::ST_IMUL;
            end
            kld_pkg::ST_IMUL:
            begin
                cmd.op     = kld_pkg::OP_IMUL;
                state_next = kld_pkg::ST_NL;
            end
            kld_pkg::ST_NL:
            begin
                cmd.op = kld_pkg::OP_NL;
                if (sel_q_reg)
                begin
                    state_next = kld_pkg::ST_DIFF;
                end
                else
                begin
                    sel_q_next = 1'b1;
                    state_next = kld_pkg::ST_LZ;
                end
            end
            kld_pkg::ST_DIFF:
            begin
                cmd.op     = kld_pkg::OP_DIFF;
                state_next = kld_pkg::ST_PMUL;
            end
            kld_pkg::ST_PMUL:
            begin
                cmd.op     = kld_pkg::OP_PMUL;
                state_next = kld_pkg::ST_ACC;
            end
            kld_pkg::ST_ACC:
            begin
                cmd.op     = kld_pkg::OP_ACC;
                state_next = status.last ? kld_pkg::ST_EMIT : kld_pkg::ST_IDLE;
            end
            kld_pkg::ST_EMIT:
            begin
                // Wait until the output word is free, then hand the sum over.
                if (!out_valid_reg || result_ready)
                begin
                    cmd.op         = kld_pkg::OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = kld_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kld_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;

endmodule

@@ rtl/core/kld_datapath.sv @@
module kld_datapath #(
    parameter int PROB_BITS      = 32,
    parameter int LOG_TABLE_BITS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic [31:0]          p_value,
    input  logic [31:0]          q_value,
    input  logic                 last_pair,
    input  kld_pkg::kld_cmd_t    cmd,
    output kld_pkg::kld_status_t status,
    output logic [47:0]          divergence,
    output logic                 invalid_run,
    output logic                 saturated
);

    localparam int TABLE_SIZE = 1 << LOG_TABLE_BITS;
    localparam int REM_W      = 31 - LOG_TABLE_BITS;
    localparam int PROD_SHIFT = PROB_BITS - 6;
    localparam int MW         = kld_pkg::MSB_W;
    localparam int SW         = kld_pkg::SUM_W;
    localparam int MAG_W_L    = kld_pkg::MAG_W;

    logic [30:0] log_rom [TABLE_SIZE+1];

    for (genvar g = 0; g <= TABLE_SIZE; g++)
    begin : g_rom
        localparam logic [30:0] ENTRY = kld_pkg::kld_log_entry(g, LOG_TABLE_BITS);
        assign log_rom[g] = ENTRY;
    end

    logic                 mode_reg;
    logic [PROB_BITS-1:0] p_reg;
    logic [PROB_BITS-1:0] q_reg;
    logic                 last_reg;
    logic                 zero_reg;
    logic [MW-1:0]        msb_reg;
    logic [30:0]          frac_reg;
    logic [30:0]          t0_reg;
    logic [30:0]          t1_reg;
    logic [63:0]          mul_reg;
    logic [31:0]          nlp_reg;
    logic [31:0]          nlq_reg;
    logic [PROB_BITS-1:0] amag_reg;
    logic                 aneg_reg;
    logic [31:0]          dmag_reg;
    logic                 dneg_reg;
    logic signed [SW-1:0] sum_reg;
    logic                 invalid_reg;
    logic                 clip_reg;
    logic [SW-1:0]        div_out_reg;
    logic                 inv_out_reg;
    logic                 sat_out_reg;

    logic [PROB_BITS-1:0] p_in;
    logic [PROB_BITS-1:0] q_in;
    logic [PROB_BITS-1:0] x_op;
    logic [31:0]          x_ext;
    logic [31:0]          x_shift;
    logic [MW-1:0]        msb_c;
    logic [LOG_TABLE_BITS:0] idx_lo;
    logic [LOG_TABLE_BITS:0] idx_hi;
    logic [31:0]          mul_a;
    logic [31:0]          mul_b;
    logic [31:0]          frac_sum;
    logic [35:0]          nl_full;
    logic [63:0]          prod_shift;
    logic [MAG_W_L-1:0]   mag;
    logic signed [SW+1:0] term;
    logic signed [SW+1:0] sum_wide;
    logic signed [SW-1:0] sum_sat;
    logic                 clip_now;

    assign p_in  = p_value[PROB_BITS-1:0];
    assign q_in  = q_value[PROB_BITS-1:0];
    assign x_op  = cmd.sel_q ? q_reg : p_reg;
    assign x_ext = 32'(x_op);

    always_comb
    begin
        msb_c = '0;
        for (int b = 0; b < PROB_BITS; b++)
        begin
            if (x_op[b])
            begin
                msb_c = MW'(b);
            end
        end
    end

    assign x_shift = x_ext << (MW'(31) - msb_reg);
    assign idx_lo  = {1'b0, frac_reg[30 -: LOG_TABLE_BITS]};
    assign idx_hi  = idx_lo + 1'b1;

    // One multiplier serves both the table interpolation and the term product.
    always_comb
    begin
        if (cmd.op == kld_pkg::OP_PMUL)
        begin
            mul_a = 32'(amag_reg);
            mul_b = dmag_reg;
        end
        else
        begin
            mul_a = (t1_reg > t0_reg) ? 32'(t1_reg - t0_reg) : 32'd0;
            mul_b = 32'(frac_reg[REM_W-1:0]);
        end
    end

    assign frac_sum = 32'(t0_reg) + mul_reg[REM_W +: 32];
    assign nl_full  = {6'(PROB_BITS) - {1'b0, msb_reg}, 30'd0} - 36'(frac_sum);

    assign prod_shift = mul_reg >> PROD_SHIFT;
    assign mag        = prod_shift[MAG_W_L-1:0];
    assign term       = (aneg_reg ^ dneg_reg) ? -$signed((SW+2)'(mag)) : $signed((SW+2)'(mag));
    assign sum_wide   = {{2{sum_reg[SW-1]}}, sum_reg} + term;

    always_comb
    begin
        clip_now = 1'b0;
        sum_sat  = sum_wide[SW-1:0];
        if (sum_wide > kld_pkg::SUM_MAX)
        begin
            clip_now = 1'b1;
            sum_sat  = kld_pkg::SUM_MAX[SW-1:0];
        end
        else if (sum_wide < kld_pkg::SUM_MIN)
        begin
            clip_now = 1'b1;
            sum_sat  = kld_pkg::SUM_MIN[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b1;
            sum_reg     <= '0;
            invalid_reg <= 1'b0;
            clip_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            case (cmd.op)
                kld_pkg::OP_LOAD:
                begin
                    if (p_in == '0 || q_in == '0)
                    begin
                        invalid_reg <= 1'b1;
                    end
                end
                kld_pkg::OP_ACC:
                begin
                    sum_reg <= sum_sat;
                    if (clip_now)
                    begin
                        clip_reg <= 1'b1;
                    end
                end
                kld_pkg::OP_EMIT:
                begin
                    sum_reg     <= '0;
                    invalid_reg <= 1'b0;
                    clip_reg    <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            kld_pkg::OP_LOAD:
            begin
                p_reg    <= p_in;
                q_reg    <= q_in;
                last_reg <= last_pair;
                zero_reg <= (p_in == '0) || (q_in == '0);
            end
            kld_pkg::OP_LZ:
            begin
                msb_reg <= msb_c;
            end
            kld_pkg::OP_NORM:
            begin
                frac_reg <= x_shift[30:0];
            end
            kld_pkg::OP_TAB:
            begin
                t0_reg <= log_rom[idx_lo];
                t1_reg <= log_rom[idx_hi];
            end
            kld_pkg::OP_IMUL, kld_pkg::OP_PMUL:
            begin
                mul_reg <= 64'(mul_a) * 64'(mul_b);
            end
            kld_pkg::OP_NL:
            begin
                if (cmd.sel_q)
                begin
                    nlq_reg <= nl_full[35:4];
                end
                else
                begin
                    nlp_reg <= nl_full[35:4];
                end
            end
            kld_pkg::OP_DIFF:
            begin
                if (mode_reg)
                begin
                    amag_reg <= (p_reg >= q_reg) ? p_reg - q_reg : q_reg - p_reg;
                    aneg_reg <= p_reg < q_reg;
                end
                else
                begin
                    amag_reg <= p_reg;
                    aneg_reg <= 1'b0;
                end
                dmag_reg <= (nlq_reg >= nlp_reg) ? nlq_reg - nlp_reg : nlp_reg - nlq_reg;
                dneg_reg <= nlp_reg > nlq_reg;
            end
            kld_pkg::OP_EMIT:
            begin
                div_out_reg <= sum_reg;
                inv_out_reg <= invalid_reg;
                sat_out_reg <= clip_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.has_zero = zero_reg;
    assign status.last     = last_reg;
    assign divergence      = div_out_reg;
    assign invalid_run     = inv_out_reg;
    assign saturated       = sat_out_reg;

endmodule

@@ rtl/core/kl_divergence_accumulator.sv @@
// Channel   Dir  Payload                                   Handshake
// pairs     in   p_value[31:0] q_value[31:0] last_pair     valid/ready
// results   out  divergence[47:0] invalid_run saturated    valid/ready
// cfg       in   cfg_wr_data (divergence_mode)             cfg_wr_en, no wait
//
// A pair with both probabilities nonzero is finished before the next pair can be taken:
// two log evaluations (leading-one search, normalize, table read, interpolation multiply,
// subtract), then the differences, the term product and the saturating add, with all
// multiplies on one shared 32x32 multiplier. A pair with a zero skips all of these steps.
// A last pair then goes through a step that loads the result word, waiting while that word is stalled.
// After reset the sum and flags are clear and the mode is symmetric.
module kl_divergence_accumulator #(
    parameter int PROB_BITS      = 32,
    parameter int LOG_TABLE_BITS = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    kld_pair_if.sink     pairs,
    kld_result_if.source results
);

    kld_pkg::kld_cmd_t    cmd;
    kld_pkg::kld_status_t status;

    kld_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pairs.valid),
        .pair_ready   (pairs.ready),
        .result_valid (results.valid),
        .result_ready (results.ready),
        .status       (status),
        .cmd          (cmd)
    );

    kld_datapath #(
        .PROB_BITS      (PROB_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .p_value     (pairs.p_value),
        .q_value     (pairs.q_value),
        .last_pair   (pairs.last_pair),
        .cmd         (cmd),
        .status      (status),
        .divergence  (results.divergence),
        .invalid_run (results.invalid_run),
        .saturated   (results.saturated)
    );

endmodule

@@ rtl/core/kld_checker.sv @@
`include "assert_macros.svh"

module kld_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pairs_valid,
    input logic        pairs_ready,
    input logic [31:0] p_value,
    input logic        last_pair,
    input logic        results_valid,
    input logic        results_ready,
    input logic [47:0] divergence
);

    // A stalled result word stays up and unchanged.
    `KLD_ASSERT_NEXT(a_result_hold, clk, rst_n, results_valid && !results_ready, results_valid && $stable(divergence))

    // The block works on one pair at a time.
    `KLD_ASSERT_NEXT(a_one_pair, clk, rst_n, pairs_valid && pairs_ready, !pairs_ready)

    // A result is only loaded while the input side is closed.
    `KLD_ASSERT_IMPL(a_emit_busy, clk, rst_n, $rose(results_valid), !$past(pairs_ready))

    // A pair that is not the last and whose p value is zero is skipped quickly.
    `KLD_ASSERT_IMPL(a_zero_skip, clk, rst_n, pairs_valid && pairs_ready && p_value == 32'd0 && !last_pair, ##2 pairs_ready)

endmodule

bind kl_divergence_accumulator kld_checker u_kld_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pairs_valid   (pairs.valid),
    .pairs_ready   (pairs.ready),
    .p_value       (pairs.p_value),
    .last_pair     (pairs.last_pair),
    .results_valid (results.valid),
    .results_ready (results.ready),
    .divergence    (results.divergence)
);
